// ----- src/bmsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmsd_pkg: shared types and constants of the BMP mask stream decoder
// Result kinds, error codes, header byte positions and the gray weights.
// ----------------------------------------------------------------------------
package bmsd_pkg;

    // Kind of a result word.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PIXEL = 2'd0;
    localparam kind_t KIND_ERROR = 2'd1;
    localparam kind_t KIND_DONE  = 2'd2;

    // Error codes carried on an error result.
    typedef logic [2:0] err_t;
    localparam err_t ERR_NONE      = 3'd0;
    localparam err_t ERR_SIGNATURE = 3'd1;
    localparam err_t ERR_DIB       = 3'd2;
    localparam err_t ERR_LAYOUT    = 3'd3;
    localparam err_t ERR_DEPTH     = 3'd4;
    localparam err_t ERR_TRUNCATED = 3'd5;

    // File byte positions; the header field ends are the last byte of each field.
    typedef logic [31:0] fpos_t;
    localparam fpos_t POS_SIG_0       = 32'd0;
    localparam fpos_t POS_SIG_1       = 32'd1;
    localparam fpos_t POS_OFFSET_END  = 32'd13;
    localparam fpos_t POS_DIB_END     = 32'd17;
    localparam fpos_t POS_WIDTH_END   = 32'd21;
    localparam fpos_t POS_HEIGHT_END  = 32'd25;
    localparam fpos_t POS_DEPTH_END   = 32'd29;
    localparam fpos_t POS_COMPR_END   = 32'd33;
    localparam fpos_t POS_HEADER_LAST = 32'd53;
    localparam fpos_t HEADER_LEN      = 32'd54;
    localparam fpos_t DIB_MIN_LEN     = 32'd40;

    localparam logic [7:0] SIG_BYTE_0 = 8'h42;
    localparam logic [7:0] SIG_BYTE_1 = 8'h4D;

    // Supported pixel depths.
    typedef logic [5:0] depth_t;
    localparam depth_t DEPTH_8  = 6'd8;
    localparam depth_t DEPTH_24 = 6'd24;
    localparam depth_t DEPTH_32 = 6'd32;

    // Gray level in thousandths: 114 b + 587 g + 299 r, compared with 1000.
    typedef logic [17:0] gray_t;
    localparam gray_t WEIGHT_B       = 18'd114;
    localparam gray_t WEIGHT_G       = 18'd587;
    localparam gray_t WEIGHT_R       = 18'd299;
    localparam gray_t GRAY_THRESHOLD = 18'd1000;

endpackage
`default_nettype wire

// ----- src/bmp_mask_stream_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_mask_stream_decoder: BMP file to binary mask, one byte per word
// Parses the 54-byte header, checks it, skips to the pixel data and gives one
// mask result per pixel with its image coordinate, in the row order of the file.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------
//  input   | in_valid/in_ready  | data_byte, end_of_file
//  output  | out_valid/out_ready| result_kind, pos_x, pos_y, inside_res,
//          |                    | error_code, img_width, img_height, last
//
//  One input word is taken per cycle while in_ready is high; a result appears in
//  the output register in the cycle after the word that causes it.
//  The output register is the only buffer: input is accepted while the register
//  is empty or being emptied in the same cycle.
//  rst_n clears all decoder state; the block then expects the first header byte.
//  Each word with end_of_file also returns the decoder to that state.
//
module bmp_mask_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_file,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bmsd_pkg::kind_t            result_kind,
    output logic [11:0]                pos_x,
    output logic [11:0]                pos_y,
    output logic                       inside_res,
    output bmsd_pkg::err_t             error_code,
    output logic [12:0]                img_width,
    output logic [12:0]                img_height,
    output logic                       last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Decoder phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_FAILED = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [31:0]       byte_pos_reg, byte_pos_next;
    logic [31:0]       shift_reg, shift_next;
    logic [31:0]       data_start_reg, data_start_next;
    logic [31:0]       dib_len_reg, dib_len_next;
    logic [WW-1:0]     width_reg, width_next;
    logic [HW-1:0]     height_reg, height_next;
    logic              top_first_reg, top_first_next;
    bmsd_pkg::depth_t  depth_reg, depth_next;
    logic [WW-1:0]     col_reg, col_next;
    logic [HW-1:0]     row_reg, row_next;
    logic [1:0]        bip_reg, bip_next;
    logic [1:0]        pad_reg, pad_next;
    bmsd_pkg::gray_t   sum_reg, sum_next;
    logic              sig_bad_reg, sig_bad_next;
    logic              layout_bad_reg, layout_bad_next;

    logic              out_valid_reg;
    bmsd_pkg::kind_t   kind_reg;
    logic [11:0]       x_reg, y_reg;
    logic              inside_reg;
    bmsd_pkg::err_t    err_reg;
    logic [12:0]       w_out_reg, h_out_reg;
    logic              last_reg;

    // Result produced by the current word.
    logic              res_fire;
    bmsd_pkg::kind_t   res_kind;
    logic [11:0]       res_x, res_y;
    logic              res_inside;
    bmsd_pkg::err_t    res_err;
    logic [12:0]       res_w, res_h;
    logic              res_last;

    logic              accept;
    logic [31:0]       shift_v;
    logic [31:0]       height_mag;
    logic [15:0]       depth_field;
    bmsd_pkg::err_t    verdict;
    logic [1:0]        final_idx;
    logic [1:0]        row_pad;
    logic [HW-1:0]     y_pix;
    bmsd_pkg::gray_t   byte_wide;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // Header shift register view including the current byte.
    assign shift_v     = {data_byte, shift_reg[31:8]};
    assign height_mag  = shift_v[31] ? (32'd0 - shift_v) : shift_v;
    assign depth_field = shift_v[31:16];

    // Pixel byte widened to the gray sum width.
    assign byte_wide = bmsd_pkg::gray_t'(data_byte);

    // Header checks in priority order: signature, DIB length, layout, depth.
    always_comb
    begin
        if (sig_bad_reg)
            verdict = bmsd_pkg::ERR_SIGNATURE;
        else if (dib_len_reg < bmsd_pkg::DIB_MIN_LEN)
            verdict = bmsd_pkg::ERR_DIB;
        else if (layout_bad_reg || data_start_reg < bmsd_pkg::HEADER_LEN)
            verdict = bmsd_pkg::ERR_LAYOUT;
        else if (depth_reg == '0)
            verdict = bmsd_pkg::ERR_DEPTH;
        else
            verdict = bmsd_pkg::ERR_NONE;
    end

    // Index of the last byte of a multi-byte pixel, and row padding bytes.
    assign final_idx = (depth_reg == bmsd_pkg::DEPTH_32) ? 2'd3 : 2'd2;

    always_comb
    begin
        if (depth_reg == bmsd_pkg::DEPTH_8)
            row_pad = 2'd0 - width_reg[1:0];
        else if (depth_reg == bmsd_pkg::DEPTH_24)
            row_pad = width_reg[1:0];
        else
            row_pad = 2'd0;
    end

    // Row in the mask: bottom-up files are flipped.
    assign y_pix = top_first_reg ? row_reg : (height_reg - HW'(1) - row_reg);

    // Next state and result for one accepted word.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_pos_next   = byte_pos_reg;
        shift_next      = shift_reg;
        data_start_next = data_start_reg;
        dib_len_next    = dib_len_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        top_first_next  = top_first_reg;
        depth_next      = depth_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        bip_next        = bip_reg;
        pad_next        = pad_reg;
        sum_next        = sum_reg;
        sig_bad_next    = sig_bad_reg;
        layout_bad_next = layout_bad_reg;

        res_fire   = 1'b0;
        res_kind   = bmsd_pkg::KIND_PIXEL;
        res_x      = '0;
        res_y      = '0;
        res_inside = 1'b0;
        res_err    = bmsd_pkg::ERR_NONE;
        res_w      = '0;
        res_h      = '0;
        res_last   = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    shift_next    = shift_v;
                    byte_pos_next = byte_pos_reg + 32'd1;
                    if (byte_pos_reg == bmsd_pkg::POS_SIG_0 && data_byte != bmsd_pkg::SIG_BYTE_0)
                        sig_bad_next = 1'b1;
                    if (byte_pos_reg == bmsd_pkg::POS_SIG_1 && data_byte != bmsd_pkg::SIG_BYTE_1)
                        sig_bad_next = 1'b1;
                    if (byte_pos_reg == bmsd_pkg::POS_OFFSET_END)
                        data_start_next = shift_v;
                    if (byte_pos_reg == bmsd_pkg::POS_DIB_END)
                        dib_len_next = shift_v;
                    if (byte_pos_reg == bmsd_pkg::POS_WIDTH_END)
                    begin
                        if (shift_v == '0 || shift_v[31] || shift_v > 32'(MAX_WIDTH))
                        begin
                            layout_bad_next = 1'b1;
                            width_next      = '0;
                        end
                        else
                            width_next = shift_v[WW-1:0];
                    end
                    if (byte_pos_reg == bmsd_pkg::POS_HEIGHT_END)
                    begin
                        top_first_next = shift_v[31];
                        if (height_mag == '0 || height_mag > 32'(MAX_HEIGHT))
                        begin
                            layout_bad_next = 1'b1;
                            height_next     = '0;
                        end
                        else
                            height_next = height_mag[HW-1:0];
                    end
                    if (byte_pos_reg == bmsd_pkg::POS_DEPTH_END)
                    begin
                        if (depth_field == 16'(bmsd_pkg::DEPTH_8)
                            || depth_field == 16'(bmsd_pkg::DEPTH_24)
                            || depth_field == 16'(bmsd_pkg::DEPTH_32))
                            depth_next = depth_field[5:0];
                        else
                            depth_next = '0;
                    end
                    if (byte_pos_reg == bmsd_pkg::POS_COMPR_END && shift_v != '0)
                        layout_bad_next = 1'b1;

                    if (byte_pos_reg == bmsd_pkg::POS_HEADER_LAST)
                    begin
                        if (verdict != bmsd_pkg::ERR_NONE)
                        begin
                            res_fire   = 1'b1;
                            res_kind   = bmsd_pkg::KIND_ERROR;
                            res_err    = verdict;
                            res_last   = 1'b1;
                            phase_next = PH_FAILED;
                        end
                        else if (end_of_file)
                        begin
                            res_fire = 1'b1;
                            res_kind = bmsd_pkg::KIND_ERROR;
                            res_err  = bmsd_pkg::ERR_TRUNCATED;
                            res_last = 1'b1;
                        end
                        else if (byte_pos_next == data_start_reg)
                            phase_next = PH_PIXEL;
                        else
                            phase_next = PH_SKIP;
                    end
                    else if (end_of_file)
                    begin
                        res_fire = 1'b1;
                        res_kind = bmsd_pkg::KIND_ERROR;
                        res_err  = bmsd_pkg::ERR_SIGNATURE;
                        res_last = 1'b1;
                    end
                end

                PH_SKIP:
                begin
                    byte_pos_next = byte_pos_reg + 32'd1;
                    if (end_of_file)
                    begin
                        res_fire = 1'b1;
                        res_kind = bmsd_pkg::KIND_ERROR;
                        res_err  = bmsd_pkg::ERR_TRUNCATED;
                        res_last = 1'b1;
                    end
                    else if (byte_pos_next == data_start_reg)
                        phase_next = PH_PIXEL;
                end

                PH_PIXEL:
                begin
                    // Running weighted sum over the blue, green and red bytes.
                    case (bip_reg)
                        2'd0:    sum_next = byte_wide * bmsd_pkg::WEIGHT_B;
                        2'd1:    sum_next = sum_reg + byte_wide * bmsd_pkg::WEIGHT_G;
                        2'd2:    sum_next = sum_reg + byte_wide * bmsd_pkg::WEIGHT_R;
                        default: sum_next = sum_reg;
                    endcase
                    if (depth_reg == bmsd_pkg::DEPTH_8)
                        sum_next = sum_reg;

                    if (depth_reg != bmsd_pkg::DEPTH_8 && bip_reg < final_idx)
                    begin
                        bip_next = bip_reg + 2'd1;
                        if (end_of_file)
                        begin
                            res_fire = 1'b1;
                            res_kind = bmsd_pkg::KIND_ERROR;
                            res_err  = bmsd_pkg::ERR_TRUNCATED;
                            res_last = 1'b1;
                        end
                    end
                    else
                    begin
                        bip_next   = 2'd0;
                        res_fire   = 1'b1;
                        res_kind   = bmsd_pkg::KIND_PIXEL;
                        res_x      = 12'(col_reg);
                        res_y      = 12'(y_pix);
                        res_inside = (depth_reg == bmsd_pkg::DEPTH_8) ? (data_byte != 8'd0)
                                                                      : (sum_next >= bmsd_pkg::GRAY_THRESHOLD);
                        res_w      = 13'(width_reg);
                        res_h      = 13'(height_reg);
                        res_last   = end_of_file;
                        col_next   = col_reg + WW'(1);
                        if (col_next >= width_reg)
                        begin
                            col_next = '0;
                            row_next = row_reg + HW'(1);
                            if (row_next >= height_reg)
                                phase_next = PH_DONE;
                            else if (row_pad != 2'd0)
                            begin
                                pad_next   = row_pad;
                                phase_next = PH_PAD;
                            end
                        end
                        // End of file before the final pixel turns this into an error.
                        if (end_of_file && phase_next != PH_DONE)
                        begin
                            res_kind   = bmsd_pkg::KIND_ERROR;
                            res_x      = '0;
                            res_y      = '0;
                            res_inside = 1'b0;
                            res_err    = bmsd_pkg::ERR_TRUNCATED;
                            res_w      = '0;
                            res_h      = '0;
                            res_last   = 1'b1;
                        end
                    end
                end

                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0)
                        phase_next = PH_PIXEL;
                    if (end_of_file)
                    begin
                        res_fire = 1'b1;
                        res_kind = bmsd_pkg::KIND_ERROR;
                        res_err  = bmsd_pkg::ERR_TRUNCATED;
                        res_last = 1'b1;
                    end
                end

                PH_DONE:
                begin
                    if (end_of_file)
                    begin
                        res_fire = 1'b1;
                        res_kind = bmsd_pkg::KIND_DONE;
                        res_w    = 13'(width_reg);
                        res_h    = 13'(height_reg);
                        res_last = 1'b1;
                    end
                end

                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Every end of file starts the next file from a clean state.
            if (end_of_file)
            begin
                phase_next      = PH_HEADER;
                byte_pos_next   = '0;
                shift_next      = '0;
                data_start_next = '0;
                dib_len_next    = '0;
                width_next      = '0;
                height_next     = '0;
                top_first_next  = 1'b0;
                depth_next      = '0;
                col_next        = '0;
                row_next        = '0;
                bip_next        = '0;
                pad_next        = '0;
                sum_next        = '0;
                sig_bad_next    = 1'b0;
                layout_bad_next = 1'b0;
            end
        end
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_pos_reg   <= '0;
            shift_reg      <= '0;
            data_start_reg <= '0;
            dib_len_reg    <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            top_first_reg  <= 1'b0;
            depth_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            bip_reg        <= '0;
            pad_reg        <= '0;
            sum_reg        <= '0;
            sig_bad_reg    <= 1'b0;
            layout_bad_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_pos_reg   <= byte_pos_next;
            shift_reg      <= shift_next;
            data_start_reg <= data_start_next;
            dib_len_reg    <= dib_len_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            top_first_reg  <= top_first_next;
            depth_reg      <= depth_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            bip_reg        <= bip_next;
            pad_reg        <= pad_next;
            sum_reg        <= sum_next;
            sig_bad_reg    <= sig_bad_next;
            layout_bad_reg <= layout_bad_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
        begin
            kind_reg   <= res_kind;
            x_reg      <= res_x;
            y_reg      <= res_y;
            inside_reg <= res_inside;
            err_reg    <= res_err;
            w_out_reg  <= res_w;
            h_out_reg  <= res_h;
            last_reg   <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign pos_x       = x_reg;
    assign pos_y       = y_reg;
    assign inside_res  = inside_reg;
    assign error_code  = err_reg;
    assign img_width   = w_out_reg;
    assign img_height  = h_out_reg;
    assign last        = last_reg;

    // An error or completion result always closes the file.
    a_final_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == bmsd_pkg::KIND_ERROR || kind_reg == bmsd_pkg::KIND_DONE)
        |-> last_reg)
        else $error("error or completion result without last");

    // A word with end of file leaves the decoder waiting for a new header.
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_file |=> phase_reg == PH_HEADER && byte_pos_reg == '0)
        else $error("decoder state not cleared after end of file");

    // The column and row counters stay inside the image while pixels are decoded.
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXEL |-> col_reg < width_reg && row_reg < height_reg)
        else $error("pixel counter outside the image");

    // Padding is only entered with bytes still to drop.
    a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> pad_reg != 2'd0)
        else $error("padding phase with no bytes left");

endmodule
`default_nettype wire

// ----- tb/tb_bmp_mask_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_mask_stream_decoder: self-checking bench for the BMP mask decoder
// Streams BMP files into the decoder one byte word at a time. The files are
// directed header and truncation cases, followed by random files, and a
// behavioral decoder in the scoreboard predicts every result word. Both
// handshakes idle and stall at random, and the result side also holds off
// for a long stretch.
// ----------------------------------------------------------------------------

localparam int IMG_MAX_W = 4096;
localparam int IMG_MAX_H = 4096;

// One result word, with its fields in port order.
typedef struct packed {
    bmsd_pkg::kind_t kind;
    logic [11:0]     x;
    logic [11:0]     y;
    logic            mask_bit;
    bmsd_pkg::err_t  err;
    logic [12:0]     w;
    logic [12:0]     h;
    logic            last;
} mask_word_t;

typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_SKIP,
    DEC_PIXEL,
    DEC_PAD,
    DEC_DONE,
    DEC_FAILED
} dec_phase_t;

typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
} rx_mode_t;

// Decodes the accepted byte stream alongside the block and checks its results.
class mask_scoreboard;
    mask_word_t      expected_q[$];
    int              failures;
    int              checked;
    int              pixel_words;
    int              error_words;
    int              done_words;

    dec_phase_t      phase;
    logic [31:0]     file_pos;
    logic [31:0]     hdr_shift;
    logic [31:0]     data_start;
    logic [31:0]     dib_len;
    logic [12:0]     width;
    logic [12:0]     height;
    logic [12:0]     col;
    logic [12:0]     row;
    logic            top_first;
    logic            sig_bad;
    logic            layout_bad;
    logic [5:0]      depth;
    logic [1:0]      byte_idx;
    logic [1:0]      pad_left;
    bmsd_pkg::gray_t gray;

    function new();
        failures    = 0;
        checked     = 0;
        pixel_words = 0;
        error_words = 0;
        done_words  = 0;
        restart();
    endfunction

    // Every end of file returns the decoder to its reset state.
    function void restart();
        phase      = DEC_HEADER;
        file_pos   = '0;
        hdr_shift  = '0;
        data_start = '0;
        dib_len    = '0;
        width      = '0;
        height     = '0;
        col        = '0;
        row        = '0;
        top_first  = 1'b0;
        sig_bad    = 1'b0;
        layout_bad = 1'b0;
        depth      = '0;
        byte_idx   = '0;
        pad_left   = '0;
        gray       = '0;
    endfunction

    function mask_word_t error_word(bmsd_pkg::err_t code);
        mask_word_t res;
        res      = '0;
        res.kind = bmsd_pkg::KIND_ERROR;
        res.err  = code;
        res.last = 1'b1;
        return res;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advances the decoder by one accepted word. Returns 0 for a word that
    // the block merely ignores.
    function bit note_word(logic [7:0] b, logic eof);
        mask_word_t     res;
        bit             fire;
        bit             active;
        bit             at_end;
        bit             image_end;
        bit             mid_pixel;
        logic [31:0]    pos;
        logic [31:0]    v;
        logic [31:0]    mag;
        logic [15:0]    bpp_field;
        logic [15:0]    row_bytes;
        logic [2:0]     last_idx;
        logic [1:0]     pad;
        logic [12:0]    y_row;
        logic           px_in;
        bmsd_pkg::err_t code;

        res       = '0;
        fire      = 1'b0;
        active    = 1'b1;
        image_end = 1'b0;
        mid_pixel = 1'b0;
        px_in     = 1'b0;

        case (phase)
            DEC_HEADER: begin
                // Little-endian header fields are taken at their last byte.
                pos       = file_pos;
                at_end    = (pos == bmsd_pkg::POS_HEADER_LAST);
                hdr_shift = {b, hdr_shift[31:8]};
                v         = hdr_shift;
                if (pos == bmsd_pkg::POS_SIG_0 && b != bmsd_pkg::SIG_BYTE_0) sig_bad = 1'b1;
                if (pos == bmsd_pkg::POS_SIG_1 && b != bmsd_pkg::SIG_BYTE_1) sig_bad = 1'b1;
                if (pos == bmsd_pkg::POS_OFFSET_END) data_start = v;
                if (pos == bmsd_pkg::POS_DIB_END) dib_len = v;
                if (pos == bmsd_pkg::POS_WIDTH_END) begin
                    if (v == 0 || v[31] || v > IMG_MAX_W) begin
                        layout_bad = 1'b1;
                        width      = '0;
                    end else begin
                        width = v[12:0];
                    end
                end
                if (pos == bmsd_pkg::POS_HEIGHT_END) begin
                    mag       = v;
                    top_first = 1'b0;
                    if (v[31]) begin
                        mag       = 32'd0 - v;
                        top_first = 1'b1;
                    end
                    if (mag == 0 || mag > IMG_MAX_H) begin
                        layout_bad = 1'b1;
                        height     = '0;
                    end else begin
                        height = mag[12:0];
                    end
                end
                if (pos == bmsd_pkg::POS_DEPTH_END) begin
                    bpp_field = v[31:16];
                    if (bpp_field == bmsd_pkg::DEPTH_8 || bpp_field == bmsd_pkg::DEPTH_24
                        || bpp_field == bmsd_pkg::DEPTH_32)
                        depth = bpp_field[5:0];
                    else
                        depth = '0;
                end
                if (pos == bmsd_pkg::POS_COMPR_END && v != 0) layout_bad = 1'b1;
                file_pos = pos + 1;

                // The header is judged on its last byte: signature, DIB length, layout, depth.
                if (at_end) begin
                    if (sig_bad)
                        code = bmsd_pkg::ERR_SIGNATURE;
                    else if (dib_len < bmsd_pkg::DIB_MIN_LEN)
                        code = bmsd_pkg::ERR_DIB;
                    else if (layout_bad || data_start < bmsd_pkg::HEADER_LEN)
                        code = bmsd_pkg::ERR_LAYOUT;
                    else if (depth == 0)
                        code = bmsd_pkg::ERR_DEPTH;
                    else
                        code = bmsd_pkg::ERR_NONE;
                    if (code != bmsd_pkg::ERR_NONE) begin
                        res   = error_word(code);
                        fire  = 1'b1;
                        phase = DEC_FAILED;
                    end else if (eof) begin
                        res  = error_word(bmsd_pkg::ERR_TRUNCATED);
                        fire = 1'b1;
                    end else begin
                        phase = (file_pos == data_start) ? DEC_PIXEL : DEC_SKIP;
                    end
                end else if (eof) begin
                    res  = error_word(bmsd_pkg::ERR_SIGNATURE);
                    fire = 1'b1;
                end
            end

            DEC_SKIP: begin
                file_pos = file_pos + 1;
                if (eof) begin
                    res  = error_word(bmsd_pkg::ERR_TRUNCATED);
                    fire = 1'b1;
                end else if (file_pos == data_start) begin
                    phase = DEC_PIXEL;
                end
            end

            DEC_PIXEL: begin
                // Gray test in thousandths; the result comes on the last byte.
                last_idx = depth[5:3] - 3'd1;
                if (depth == bmsd_pkg::DEPTH_8) begin
                    px_in = (b != 8'd0);
                end else begin
                    case (byte_idx)
                        2'd0:    gray = bmsd_pkg::WEIGHT_B * b;
                        2'd1:    gray = gray + bmsd_pkg::WEIGHT_G * b;
                        2'd2:    gray = gray + bmsd_pkg::WEIGHT_R * b;
                        default: ;
                    endcase
                    if ({1'b0, byte_idx} < last_idx) begin
                        mid_pixel = 1'b1;
                        byte_idx  = byte_idx + 2'd1;
                        if (eof) begin
                            res  = error_word(bmsd_pkg::ERR_TRUNCATED);
                            fire = 1'b1;
                        end
                    end
                    px_in = (gray >= bmsd_pkg::GRAY_THRESHOLD);
                end
                if (!mid_pixel) begin
                    byte_idx     = '0;
                    y_row        = top_first ? row : height - 13'd1 - row;
                    res.kind     = bmsd_pkg::KIND_PIXEL;
                    res.x        = col[11:0];
                    res.y        = y_row[11:0];
                    res.mask_bit = px_in;
                    res.w        = width;
                    res.h        = height;
                    res.last     = eof;
                    col          = col + 13'd1;
                    if (col >= width) begin
                        row_bytes = width * depth[5:3];
                        pad       = 2'd0 - row_bytes[1:0];
                        col       = '0;
                        row       = row + 13'd1;
                        if (row >= height) begin
                            image_end = 1'b1;
                            phase     = DEC_DONE;
                        end else if (pad != 0) begin
                            pad_left = pad;
                            phase    = DEC_PAD;
                        end
                    end
                    if (eof && !image_end) res = error_word(bmsd_pkg::ERR_TRUNCATED);
                    fire = 1'b1;
                end
            end

            DEC_PAD: begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 0) phase = DEC_PIXEL;
                if (eof) begin
                    res  = error_word(bmsd_pkg::ERR_TRUNCATED);
                    fire = 1'b1;
                end
            end

            DEC_DONE: begin
                active = eof;
                if (eof) begin
                    res.kind = bmsd_pkg::KIND_DONE;
                    res.w    = width;
                    res.h    = height;
                    res.last = 1'b1;
                    fire     = 1'b1;
                end
            end

            default: active = eof;
        endcase

        if (fire) begin
            expected_q = {expected_q, res};
            case (res.kind)
                bmsd_pkg::KIND_PIXEL: pixel_words++;
                bmsd_pkg::KIND_ERROR: error_words++;
                default:              done_words++;
            endcase
        end
        if (eof) restart();
        return active;
    endfunction

    function void show(string tag, mask_word_t w);
        $display("  %s: kind %0d x %0d y %0d mask %0b err %0d w %0d h %0d last %0b",
                 tag, w.kind, w.x, w.y, w.mask_bit, w.err, w.w, w.h, w.last);
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void check_word(mask_word_t got);
        mask_word_t want;
        checked++;
        if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("Result word %0d arrived with nothing predicted:", checked);
                show("actual", got);
            end
            return;
        end
        want = expected_q.pop_front();
        if (got.kind != want.kind || got.x != want.x || got.y != want.y ||
            got.mask_bit != want.mask_bit || got.err != want.err || got.w != want.w ||
            got.h != want.h || got.last != want.last) begin
            failures++;
            if (failures <= 10) begin
                $display("Mismatch on result word %0d:", checked);
                show("expected", want);
                show("actual  ", got);
            end
        end
    endfunction
endclass

module tb_bmp_mask_stream_decoder;

    localparam int HALF_PERIOD   = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_GOAL     = 1150;
    localparam int LIMIT_NS      = 10_000_000;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [7:0]      data_byte;
    logic            end_of_file;
    logic            out_valid;
    logic            out_ready;
    bmsd_pkg::kind_t result_kind;
    logic [11:0]     pos_x;
    logic [11:0]     pos_y;
    logic            inside_res;
    bmsd_pkg::err_t  error_code;
    logic [12:0]     img_width;
    logic [12:0]     img_height;
    logic            last;

    mask_scoreboard sb;
    logic [7:0]     file_q[$];
    int             burst_left;
    bit             gaps_on;
    int             files_sent;
    int             active_words;
    int             words_sent;
    int             first_random;
    logic           hold_req;
    int             hold_left;
    rx_mode_t       rx_mode;
    int             rx_mode_left;
    int             rx_phase;

    bmp_mask_stream_decoder #(
        .MAX_WIDTH  (IMG_MAX_W),
        .MAX_HEIGHT (IMG_MAX_H)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .inside_res  (inside_res),
        .error_code  (error_code),
        .img_width   (img_width),
        .img_height  (img_height),
        .last        (last)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Result side: check each accepted word, then choose the next ready level.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_word({result_kind, pos_x, pos_y, inside_res, error_code,
                               img_width, img_height, last});
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(40, 200);
            end
            rx_mode_left--;
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:     out_ready <= 1'b1;
                    RX_COIN:     out_ready <= $urandom_range(0, 1);
                    RX_PERIODIC: out_ready <= (rx_phase % 3 != 0);
                    default:     out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Pixel bytes lean toward zero and small values so both mask levels occur.
    function automatic logic [7:0] pixel_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'($urandom_range(1, 3));
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Length of a file that ends on the last byte of its final pixel.
    function automatic int pixel_end(int offset, int w, int rows, int bpp);
        int row_len;
        int stride;
        row_len = w * bpp / 8;
        stride  = (row_len + 3) / 4 * 4;
        return offset + stride * (rows - 1) + row_len;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        file_q = {file_q, b};
    endtask

    task automatic put32(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            add_byte(v[8*k +: 8]);
    endtask

    task automatic set32(input int idx, input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            file_q[idx + k] = v[8*k +: 8];
    endtask

    task automatic build_header(input logic [31:0] offset, input logic [31:0] dib,
                                input logic [31:0] w, input logic [31:0] h,
                                input int bpp, input logic [31:0] compr);
        file_q.delete();
        add_byte(bmsd_pkg::SIG_BYTE_0);
        add_byte(bmsd_pkg::SIG_BYTE_1);
        put32($urandom);
        put32($urandom);
        put32(offset);
        put32(dib);
        put32(w);
        put32(h);
        put32({16'(bpp), 16'($urandom)});
        put32(compr);
        repeat (20) add_byte(8'($urandom_range(0, 255)));
    endtask

    // Offers one word and holds it until the block takes it; gaps follow bursts.
    task automatic send_word(input logic [7:0] b, input logic eof);
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (sb.note_word(b, eof)) active_words++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Sends n bytes of the file, padding past the stored part with pixel bytes.
    task automatic send_file(input int n);
        for (int i = 0; i < n; i++)
            send_word((i < file_q.size()) ? file_q[i] : pixel_byte(), i == n - 1);
        files_sent++;
    endtask

    task automatic header_file(input logic [31:0] offset, input logic [31:0] dib,
                               input logic [31:0] w, input logic [31:0] h,
                               input int bpp, input logic [31:0] compr,
                               input int n);
        build_header(offset, dib, w, h, bpp, compr);
        send_file(n);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Mostly well-formed small images with random pixels; the rest are broken
    // headers and noise.
    task automatic random_file();
        int          w;
        int          rows;
        int          bpp;
        int          offset;
        int          full;
        int          n;
        int          pick;
        logic [31:0] dib;
        logic [31:0] h_field;

        w    = $urandom_range(1, 7);
        rows = $urandom_range(1, 4);
        case ($urandom_range(0, 2))
            0:       bpp = 8;
            1:       bpp = 24;
            default: bpp = 32;
        endcase
        offset  = ($urandom_range(0, 2) == 0) ? 54 + $urandom_range(1, 6) : 54;
        dib     = $urandom_range(0, 1) ? 32'd40 : $urandom_range(40, 140);
        h_field = $urandom_range(0, 1) ? -rows : rows;
        build_header(offset, dib, w, h_field, bpp, 32'd0);
        full = pixel_end(offset, w, rows, bpp);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            n = full + $urandom_range(1, 6);
        end else if (pick < 70) begin
            n = full;
        end else if (pick < 85) begin
            n = $urandom_range(54, full - 1);
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 6))
                    0: file_q[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
                    1: set32(14, $urandom_range(0, 39));
                    2: set32(18, $urandom_range(0, 1) ? 32'd4097 : $urandom | 32'h8000_0000);
                    3: set32(22, $urandom_range(0, 1) ? -32'd4097 : $urandom);
                    4: begin
                        file_q[28] = 8'($urandom_range(0, 255));
                        file_q[29] = 8'($urandom_range(0, 255));
                    end
                    5: set32(30, $urandom_range(1, 3));
                    default: set32(10, $urandom_range(0, 53));
                endcase
            end
            n = 54 + $urandom_range(0, 6);
        end else begin
            file_q.delete();
            n = $urandom_range(1, 70);
        end
        send_file(n);
    endtask

    initial begin
        #LIMIT_NS;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        end_of_file  = 1'b0;
        out_ready    = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        rx_mode      = RX_OPEN;
        rx_mode_left = 0;
        rx_phase     = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        files_sent   = 0;
        active_words = 0;
        words_sent   = 0;
        first_random = 0;
        sb           = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bottom-up 8 bpp with row padding, trailing bytes and completion.
        build_header(54, 40, 3, 2, 8, 0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(8'hAA);
        add_byte(8'h80);
        add_byte(8'h00);
        add_byte(8'h7F);
        send_file(pixel_end(54, 3, 2, 8) + 3);

        // Top-down 24 bpp after a skip, gray right at and below the threshold,
        // ending on the final pixel byte.
        build_header(58, 40, 2, -2, 24, 0);
        repeat (4) add_byte(8'($urandom_range(0, 255)));
        add_byte(8'h01);
        add_byte(8'h01);
        add_byte(8'h01);
        add_byte(8'h00);
        add_byte(8'h01);
        add_byte(8'h01);
        add_byte(8'h55);
        add_byte(8'hAA);
        repeat (3) add_byte(8'hFF);
        repeat (3) add_byte(8'h00);
        send_file(pixel_end(58, 2, 2, 24));

        // 32 bpp single pixel, normal completion.
        header_file(54, 40, 1, 1, 32, 0, pixel_end(54, 1, 1, 32) + 2);

        // Signature fault outranks a depth fault; the tail is ignored.
        build_header(54, 40, 2, 2, 16, 0);
        file_q[1] = 8'h4E;
        send_file(57);

        // Header faults, one per file.
        header_file(54, 39, 2, 2, 8, 0, 54);
        header_file(54, 40, 4097, 2, 8, 0, 54);
        header_file(54, 40, 2, 0, 8, 0, 54);
        header_file(54, 40, 2, 2, 8, 1, 54);
        header_file(53, 40, 2, 2, 8, 0, 54);
        header_file(54, 40, 2, 2, 16, 0, 54);

        // End of file inside the header, on its last byte, in the skip,
        // inside a pixel and in the padding of a row that is not the last.
        header_file(54, 40, 2, 2, 8, 0, 1);
        header_file(54, 40, 2, 2, 8, 0, 54);
        header_file(70, 40, 2, 2, 8, 0, 60);
        header_file(54, 40, 2, 2, 24, 0, 55);
        header_file(54, 40, 1, 2, 8, 0, 56);

        // Largest sizes: deepest bottom row and top-down at full size.
        header_file(54, 40, IMG_MAX_W, IMG_MAX_H, 8, 0, 59);
        header_file(54, 40, IMG_MAX_W, -IMG_MAX_H, 32, 0, 64);

        // Random files; one long result-side hold while words keep coming.
        wait_drained();
        first_random = files_sent;
        while (words_sent < ITEM_GOAL || files_sent < first_random + 3) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) wait_drained();
            if (files_sent == first_random) hold_req <= 1'b1;
            random_file();
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d files in %0d byte words (%0d decoded): %0d pixel, %0d error, %0d done.",
                 files_sent, words_sent, active_words, sb.pixel_words, sb.error_words,
                 sb.done_words);
        $display("Checked %0d result words, %0d failing.", sb.checked, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- bmp_mask_stream_decoder.f -----
src/bmsd_pkg.sv
src/bmp_mask_stream_decoder.sv
tb/tb_bmp_mask_stream_decoder.sv
